// ===== design/period_schedule_generator_assert.svh =====
// Assertion macros shared by the schedule generator modules.
`ifndef PERIOD_SCHEDULE_GENERATOR_ASSERT_SVH
`define PERIOD_SCHEDULE_GENERATOR_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define PSG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("period schedule generator assertion failed");

// Condition must never be seen outside reset.
`define PSG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("period schedule generator forbidden condition seen");

`endif

// ===== design/psg_pkg.sv =====
// Shared types, constants, calendar helpers and control store of the schedule generator.
package psg_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned StepW  = 4;
  localparam int unsigned ResW   = 9;   // year modulo 400
  localparam int unsigned QuotW  = 6;   // year / 400
  localparam int unsigned KeyW   = YearW + MonthW + DayW;

  localparam int unsigned MaxPeriodsDef = 64;

  // floor(y / 400) == (y * QuotMul) >> QuotShift for every 14-bit year
  localparam int unsigned QuotMul   = 5243;
  localparam int unsigned QuotShift = 21;
  localparam int unsigned ProdW     = 27;

  localparam logic [StepW-1:0] MonthsPerStepRst = StepW'(6);

  typedef enum logic [0:0] {
    CFG_MONTHS_PER_STEP = 1'b0,
    CFG_KEEP_MONTH_END  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_WAIT   = 3'd0,
    ST_QUOT   = 3'd1,
    ST_RES    = 3'd2,
    ST_NORM   = 3'd3,
    ST_TEST   = 3'd4,
    ST_ROLL   = 3'd5,
    ST_EMIT   = 3'd6,
    ST_SINGLE = 3'd7
  } step_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_IN,
    COND_GE,
    COND_EMIT
  } cond_e;

  typedef struct packed {
    logic  ld_in;
    logic  calc_q;
    logic  calc_r;
    logic  norm;
    logic  roll;
    logic  emit;
    logic  emit_single;
    cond_e cond;
    step_e target;
  } ctrl_t;

  typedef struct packed {
    logic ge;        // current date at or past end date
    logic is_last;   // the period being emitted closes the run
    logic out_free;  // output register can take a result
  } psg_status_t;

  localparam ctrl_t CtrlNop = '{
    ld_in: 1'b0, calc_q: 1'b0, calc_r: 1'b0, norm: 1'b0, roll: 1'b0,
    emit: 1'b0, emit_single: 1'b0, cond: COND_NEXT, target: ST_WAIT
  };

  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c = CtrlNop;
    unique case (s)
      ST_WAIT: begin
        c.ld_in = 1'b1;
        c.cond  = COND_IN;
      end
      ST_QUOT: c.calc_q = 1'b1;
      ST_RES:  c.calc_r = 1'b1;
      ST_NORM: c.norm   = 1'b1;
      ST_TEST: begin
        c.cond   = COND_GE;
        c.target = ST_SINGLE;
      end
      ST_ROLL: c.roll = 1'b1;
      ST_EMIT: begin
        c.emit   = 1'b1;
        c.cond   = COND_EMIT;
        c.target = ST_ROLL;
      end
      ST_SINGLE: begin
        c.emit        = 1'b1;
        c.emit_single = 1'b1;
        c.cond        = COND_EMIT;
        c.target      = ST_WAIT;
      end
      default: c = CtrlNop;
    endcase
    return c;
  endfunction

  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] m);
    logic [DayW-1:0] d;
    unique case (m)
      4'd2:                      d = DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   d = DayW'(30);
      default:                   d = DayW'(31);
    endcase
    return d;
  endfunction

  // Gregorian leap test from the year's residue modulo 400
  function automatic logic is_leap(logic [ResW-1:0] r);
    return (r[1:0] == 2'b00) && (r != ResW'(100)) && (r != ResW'(200))
        && (r != ResW'(300));
  endfunction

  function automatic logic [DayW-1:0] days_of(logic [ResW-1:0] r, logic [MonthW-1:0] m);
    logic [DayW-1:0] d;
    d = month_len(m);
    if (m == MonthW'(2) && is_leap(r)) d = DayW'(29);
    return d;
  endfunction

endpackage

// ===== design/psg_sequencer.sv =====
// Step counter and control store that drive the schedule datapath.
module psg_sequencer import psg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  psg_status_t status_i,
  output ctrl_t       ctrl_o,
  output logic        in_stall_o
);

  step_e step_q, step_d;
  ctrl_t cw;

  assign cw         = ucode(step_q);
  assign ctrl_o     = cw;
  assign in_stall_o = ~cw.ld_in;

  always_comb begin
    step_d = step_q;
    unique case (cw.cond)
      COND_NEXT: step_d = step_e'(step_q + 3'd1);
      COND_JUMP: step_d = cw.target;
      COND_IN:   if (in_valid_i) step_d = step_e'(step_q + 3'd1);
      COND_GE:   step_d = status_i.ge ? cw.target : step_e'(step_q + 3'd1);
      COND_EMIT: begin
        // hold while the output register is full and stalled
        if (status_i.out_free) step_d = status_i.is_last ? ST_WAIT : cw.target;
      end
      default:   step_d = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

`include "period_schedule_generator_assert.svh"

  `PSG_ASSERT(a_busy_after_request, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `PSG_ASSERT(a_stall_outside_wait, (step_q != ST_WAIT) |-> in_stall_o)

endmodule

// ===== design/psg_datapath.sv =====
// Date registers, month roll, clamping and output register of the schedule generator.
module psg_datapath import psg_pkg::*; #(
  parameter int unsigned MAX_PERIODS = MaxPeriodsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  output psg_status_t       status_o,
  input  logic [StepW-1:0]  months_per_step_i,
  input  logic              keep_month_end_i,
  input  logic              in_valid_i,
  input  logic [YearW-1:0]  start_year_i,
  input  logic [MonthW-1:0] start_month_i,
  input  logic [DayW-1:0]   start_day_i,
  input  logic [YearW-1:0]  end_year_i,
  input  logic [MonthW-1:0] end_month_i,
  input  logic [DayW-1:0]   end_day_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [YearW-1:0]  period_start_year_o,
  output logic [MonthW-1:0] period_start_month_o,
  output logic [DayW-1:0]   period_start_day_o,
  output logic [YearW-1:0]  period_end_year_o,
  output logic [MonthW-1:0] period_end_month_o,
  output logic [DayW-1:0]   period_end_day_o,
  output logic              last_period_o,
  output logic              truncated_o
);

  localparam int unsigned CntW = $clog2(MAX_PERIODS + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_PERIODS - 1);

  // raw request
  logic [YearW-1:0]  raw_sy_q, raw_ey_q;
  logic [MonthW-1:0] raw_sm_q, raw_em_q;
  logic [DayW-1:0]   raw_sd_q, raw_ed_q;
  logic [QuotW-1:0]  qs_q, qe_q;
  logic [ResW-1:0]   rs_q, re_q;

  // current and end dates
  logic [YearW-1:0]  cur_y_q, end_y_q;
  logic [MonthW-1:0] cur_m_q, end_m_q;
  logic [DayW-1:0]   cur_d_q, end_d_q, cur_lim_q;
  logic [ResW-1:0]   cur_r_q;
  logic [CntW-1:0]   cnt_q;

  // rolled date
  logic [YearW:0]    nxt_y_q;
  logic [MonthW-1:0] nxt_m_q;
  logic [DayW-1:0]   nxt_d_q, nxt_lim_q;
  logic [ResW-1:0]   nxt_r_q;

  logic              out_valid_q;
  logic [YearW-1:0]  o_sy_q, o_ey_q;
  logic [MonthW-1:0] o_sm_q, o_em_q;
  logic [DayW-1:0]   o_sd_q, o_ed_q;
  logic              o_last_q, o_trunc_q;

  logic [ProdW-1:0]  prod_s, prod_e;
  logic [YearW-1:0]  rem_s, rem_e;
  logic [MonthW-1:0] ns_m, ne_m;
  logic [DayW-1:0]   ns_lim, ne_lim, ns_d, ne_d;
  logic [StepW-1:0]  step;
  logic [MonthW:0]   msum;
  logic [MonthW-1:0] roll_m;
  logic [1:0]        carry;
  logic [ResW:0]     rsum;
  logic [ResW-1:0]   roll_r;
  logic [DayW-1:0]   roll_lim, roll_d;
  logic              ge_next, cnt_end, out_free, do_emit;

  function automatic logic [MonthW-1:0] clamp_month(logic [MonthW-1:0] m);
    logic [MonthW-1:0] r;
    r = m;
    if (m == '0) r = MonthW'(1);
    else if (m > MonthW'(12)) r = MonthW'(12);
    return r;
  endfunction

  function automatic logic [DayW-1:0] clamp_day(logic [DayW-1:0] d, logic [DayW-1:0] lim);
    logic [DayW-1:0] r;
    r = d;
    if (d == '0) r = DayW'(1);
    else if (d > lim) r = lim;
    return r;
  endfunction

  // year / 400 by reciprocal in ST_QUOT, then the residue from it in ST_RES
  assign prod_s = ProdW'(raw_sy_q) * ProdW'(QuotMul);
  assign prod_e = ProdW'(raw_ey_q) * ProdW'(QuotMul);
  assign rem_s  = raw_sy_q - YearW'(qs_q) * YearW'(400);
  assign rem_e  = raw_ey_q - YearW'(qe_q) * YearW'(400);

  assign ns_m   = clamp_month(raw_sm_q);
  assign ne_m   = clamp_month(raw_em_q);
  assign ns_lim = days_of(rs_q, ns_m);
  assign ne_lim = days_of(re_q, ne_m);
  assign ns_d   = clamp_day(raw_sd_q, ns_lim);
  assign ne_d   = clamp_day(raw_ed_q, ne_lim);

  // month roll, carrying into the year at most twice
  assign step = (months_per_step_i == '0) ? StepW'(1) : months_per_step_i;
  assign msum = (MonthW+1)'(cur_m_q) + (MonthW+1)'(step);

  always_comb begin
    if (msum > (MonthW+1)'(24)) begin
      roll_m = MonthW'(msum - (MonthW+1)'(24));
      carry  = 2'd2;
    end else if (msum > (MonthW+1)'(12)) begin
      roll_m = MonthW'(msum - (MonthW+1)'(12));
      carry  = 2'd1;
    end else begin
      roll_m = MonthW'(msum);
      carry  = 2'd0;
    end
  end

  assign rsum     = (ResW+1)'(cur_r_q) + (ResW+1)'(carry);
  assign roll_r   = (rsum >= (ResW+1)'(400)) ? ResW'(rsum - (ResW+1)'(400)) : ResW'(rsum);
  assign roll_lim = days_of(roll_r, roll_m);

  always_comb begin
    if (keep_month_end_i && cur_d_q == cur_lim_q) roll_d = roll_lim;
    else roll_d = (cur_d_q < roll_lim) ? cur_d_q : roll_lim;
  end

  assign ge_next  = {nxt_y_q, nxt_m_q, nxt_d_q} >= {1'b0, end_y_q, end_m_q, end_d_q};
  assign cnt_end  = (cnt_q == CntLast);
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign do_emit  = ctrl_i.emit & out_free;

  assign status_o.ge       = {cur_y_q, cur_m_q, cur_d_q} >= {end_y_q, end_m_q, end_d_q};
  assign status_o.is_last  = ctrl_i.emit_single | ge_next | cnt_end;
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_in && in_valid_i) begin
      raw_sy_q <= start_year_i;
      raw_sm_q <= start_month_i;
      raw_sd_q <= start_day_i;
      raw_ey_q <= end_year_i;
      raw_em_q <= end_month_i;
      raw_ed_q <= end_day_i;
    end
    if (ctrl_i.calc_q) begin
      qs_q <= prod_s[QuotShift +: QuotW];
      qe_q <= prod_e[QuotShift +: QuotW];
    end
    if (ctrl_i.calc_r) begin
      rs_q <= rem_s[ResW-1:0];
      re_q <= rem_e[ResW-1:0];
    end
    if (ctrl_i.norm) begin
      cur_y_q   <= raw_sy_q;
      cur_m_q   <= ns_m;
      cur_d_q   <= ns_d;
      cur_r_q   <= rs_q;
      cur_lim_q <= ns_lim;
      end_y_q   <= raw_ey_q;
      end_m_q   <= ne_m;
      end_d_q   <= ne_d;
    end
    if (ctrl_i.roll) begin
      nxt_y_q   <= (YearW+1)'(cur_y_q) + (YearW+1)'(carry);
      nxt_m_q   <= roll_m;
      nxt_d_q   <= roll_d;
      nxt_r_q   <= roll_r;
      nxt_lim_q <= roll_lim;
    end
    // advance to the rolled date once a mid-run period has gone out
    if (do_emit && !ctrl_i.emit_single && !ge_next && !cnt_end) begin
      cur_y_q   <= nxt_y_q[YearW-1:0];
      cur_m_q   <= nxt_m_q;
      cur_d_q   <= nxt_d_q;
      cur_r_q   <= nxt_r_q;
      cur_lim_q <= nxt_lim_q;
    end
    if (do_emit) begin
      o_sy_q <= cur_y_q;
      o_sm_q <= cur_m_q;
      o_sd_q <= cur_d_q;
      if (ctrl_i.emit_single || ge_next) begin
        o_ey_q    <= end_y_q;
        o_em_q    <= end_m_q;
        o_ed_q    <= end_d_q;
        o_last_q  <= 1'b1;
        o_trunc_q <= 1'b0;
      end else begin
        o_ey_q    <= nxt_y_q[YearW-1:0];
        o_em_q    <= nxt_m_q;
        o_ed_q    <= nxt_d_q;
        o_last_q  <= cnt_end;
        o_trunc_q <= cnt_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (do_emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (ctrl_i.norm) cnt_q <= '0;
      else if (do_emit && !ctrl_i.emit_single && !ge_next && !cnt_end) cnt_q <= cnt_q + 1'b1;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign period_start_year_o  = o_sy_q;
  assign period_start_month_o = o_sm_q;
  assign period_start_day_o   = o_sd_q;
  assign period_end_year_o    = o_ey_q;
  assign period_end_month_o   = o_em_q;
  assign period_end_day_o     = o_ed_q;
  assign last_period_o        = o_last_q;
  assign truncated_o          = o_trunc_q;

`include "period_schedule_generator_assert.svh"

  `PSG_ASSERT_NEVER(a_trunc_without_last, out_valid_q && o_trunc_q && !o_last_q)
  `PSG_ASSERT_NEVER(a_count_in_range, cnt_q > CntLast)
  `PSG_ASSERT(a_emit_only_when_free, do_emit |-> (!out_valid_q || !out_stall_i))

endmodule

// ===== design/period_schedule_generator.sv =====
// Top level: a request of two dates becomes a run of periods, 1 to MAX_PERIODS results.
// The first result is registered after the quotient, residue, normalise, compare and roll steps.
// A single period skips the roll. Each period takes a month roll step, then a compare and emit
// step that holds on output stalls; periods go out one at a time through the roll/compare datapath.
// Requests are taken only between runs; the config port is always ready.
// Reset: months_per_step = 6, keep_month_end = 0, sequencer waits, no result pending.
module period_schedule_generator import psg_pkg::*; #(
  parameter int unsigned MAX_PERIODS = MaxPeriodsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [StepW-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [YearW-1:0]  start_year_i,
  input  logic [MonthW-1:0] start_month_i,
  input  logic [DayW-1:0]   start_day_i,
  input  logic [YearW-1:0]  end_year_i,
  input  logic [MonthW-1:0] end_month_i,
  input  logic [DayW-1:0]   end_day_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [YearW-1:0]  period_start_year_o,
  output logic [MonthW-1:0] period_start_month_o,
  output logic [DayW-1:0]   period_start_day_o,
  output logic [YearW-1:0]  period_end_year_o,
  output logic [MonthW-1:0] period_end_month_o,
  output logic [DayW-1:0]   period_end_day_o,
  output logic              last_period_o,
  output logic              truncated_o
);

  logic [StepW-1:0] months_per_step_q;
  logic             keep_month_end_q;
  ctrl_t            ctrl;
  psg_status_t      status;
  cfg_idx_e         cfg_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      months_per_step_q <= MonthsPerStepRst;
      keep_month_end_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx)
        CFG_MONTHS_PER_STEP: months_per_step_q <= cfg_data_i;
        CFG_KEEP_MONTH_END:  keep_month_end_q  <= cfg_data_i[0];
        default:             months_per_step_q <= months_per_step_q;
      endcase
    end
  end

  psg_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  psg_datapath #(
    .MAX_PERIODS (MAX_PERIODS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ctrl_i               (ctrl),
    .status_o             (status),
    .months_per_step_i    (months_per_step_q),
    .keep_month_end_i     (keep_month_end_q),
    .in_valid_i           (in_valid_i),
    .start_year_i         (start_year_i),
    .start_month_i        (start_month_i),
    .start_day_i          (start_day_i),
    .end_year_i           (end_year_i),
    .end_month_i          (end_month_i),
    .end_day_i            (end_day_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .period_start_year_o  (period_start_year_o),
    .period_start_month_o (period_start_month_o),
    .period_start_day_o   (period_start_day_o),
    .period_end_year_o    (period_end_year_o),
    .period_end_month_o   (period_end_month_o),
    .period_end_day_o     (period_end_day_o),
    .last_period_o        (last_period_o),
    .truncated_o          (truncated_o)
  );

endmodule
